FILE: rtl/arp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// Codes and item types for the AArch64 relocation patcher.
// ----------------------------------------------------------------------------
package arp_pkg;

	// relocation kinds
	localparam logic [3:0] CMD_ABS64    = 4'd0;
	localparam logic [3:0] CMD_PREL64   = 4'd1;
	localparam logic [3:0] CMD_ABS32    = 4'd2;
	localparam logic [3:0] CMD_PREL32   = 4'd3;
	localparam logic [3:0] CMD_CALL26   = 4'd4;
	localparam logic [3:0] CMD_JUMP26   = 4'd5;
	localparam logic [3:0] CMD_CONDBR19 = 4'd6;
	localparam logic [3:0] CMD_TSTBR14  = 4'd7;
	localparam logic [3:0] CMD_ADRP     = 4'd8;
	localparam logic [3:0] CMD_ADDLO12  = 4'd9;
	localparam logic [3:0] CMD_LDSTLO12 = 4'd10;
	localparam logic [3:0] CMD_MOVW_G0  = 4'd11;
	localparam logic [3:0] CMD_MOVW_G1  = 4'd12;
	localparam logic [3:0] CMD_MOVW_G2  = 4'd13;
	localparam logic [3:0] CMD_MOVW_G3  = 4'd14;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_ROOM = 3'd1;
	localparam logic [2:0] ST_RANGE   = 3'd2;
	localparam logic [2:0] ST_ALIGN   = 3'd3;
	localparam logic [2:0] ST_UNSUP   = 3'd4;

	// range forms reported with ST_RANGE
	localparam logic [2:0] FORM_NONE   = 3'd0;
	localparam logic [2:0] FORM_BRANCH = 3'd1;
	localparam logic [2:0] FORM_COND   = 3'd2;
	localparam logic [2:0] FORM_TEST   = 3'd3;
	localparam logic [2:0] FORM_PAGE   = 3'd4;
	localparam logic [2:0] FORM_PREL32 = 3'd5;

	localparam logic [3:0] BYTES_NONE = 4'd0;
	localparam logic [3:0] BYTES_WORD = 4'd4;
	localparam logic [3:0] BYTES_DWORD = 4'd8;

	typedef struct packed {
		logic [3:0]         command;
		logic [63:0]        target_address;
		logic signed [63:0] addend;
		logic [63:0]        site_address;
		logic [31:0]        old_word;
		logic [3:0]         room_bytes;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  write_bytes;
		logic [63:0] patched_value;
		logic [2:0]  range_form;
	} rsp_t;

endpackage

FILE: rtl/arp_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_calc
// Combinational relocation evaluation: value, delta, checks and field insert.
// ----------------------------------------------------------------------------
module arp_calc (
	input  arp_pkg::req_t req,
	output arp_pkg::rsp_t rsp
);

	logic [63:0] value;
	logic [63:0] delta;
	logic [51:0] pages;
	logic [3:0]  need;
	logic [2:0]  sc;
	logic        misal;
	logic [11:0] lo12;
	logic [15:0] half;
	logic [31:0] w;

	assign value = req.target_address + $unsigned(req.addend);
	assign delta = value - req.site_address;
	// page difference, already shifted down by 12
	assign pages = value[63:12] - req.site_address[63:12];
	assign w     = req.old_word;

	always_comb begin
		need = (req.command <= arp_pkg::CMD_PREL64) ? arp_pkg::BYTES_DWORD
			: arp_pkg::BYTES_WORD;

		// load/store access size; 128-bit vector form scales by 16
		sc = {1'b0, w[31:30]};
		if (w[31:30] == 2'b00 && w[26] && w[23]) begin
			sc = 3'd4;
		end
		case (sc)
			3'd0: misal = 1'b0;
			3'd1: misal = value[0];
			3'd2: misal = |value[1:0];
			3'd3: misal = |value[2:0];
			default: misal = |value[3:0];
		endcase
		lo12 = value[11:0] >> sc;

		case (req.command)
			arp_pkg::CMD_MOVW_G0: half = value[15:0];
			arp_pkg::CMD_MOVW_G1: half = value[31:16];
			arp_pkg::CMD_MOVW_G2: half = value[47:32];
			default:              half = value[63:48];
		endcase

		rsp.status        = arp_pkg::ST_OK;
		rsp.range_form    = arp_pkg::FORM_NONE;
		rsp.patched_value = '0;

		if (req.room_bytes < need) begin
			rsp.status = arp_pkg::ST_NO_ROOM;
		end else begin
			case (req.command)
				arp_pkg::CMD_ABS64: rsp.patched_value = value;
				arp_pkg::CMD_PREL64: rsp.patched_value = delta;
				arp_pkg::CMD_ABS32: rsp.patched_value = {32'd0, value[31:0]};
				arp_pkg::CMD_PREL32: begin
					if ((&delta[63:31]) || !(|delta[63:31])) begin
						rsp.patched_value = {32'd0, delta[31:0]};
					end else begin
						rsp.status     = arp_pkg::ST_RANGE;
						rsp.range_form = arp_pkg::FORM_PREL32;
					end
				end
				arp_pkg::CMD_CALL26, arp_pkg::CMD_JUMP26: begin
					if (!(|delta[1:0]) && ((&delta[63:27]) || !(|delta[63:27]))) begin
						rsp.patched_value = {32'd0, w[31:26], delta[27:2]};
					end else begin
						rsp.status     = arp_pkg::ST_RANGE;
						rsp.range_form = arp_pkg::FORM_BRANCH;
					end
				end
				arp_pkg::CMD_CONDBR19: begin
					if (!(|delta[1:0]) && ((&delta[63:20]) || !(|delta[63:20]))) begin
						rsp.patched_value = {32'd0, w[31:24], delta[20:2], w[4:0]};
					end else begin
						rsp.status     = arp_pkg::ST_RANGE;
						rsp.range_form = arp_pkg::FORM_COND;
					end
				end
				arp_pkg::CMD_TSTBR14: begin
					if (!(|delta[1:0]) && ((&delta[63:15]) || !(|delta[63:15]))) begin
						rsp.patched_value = {32'd0, w[31:19], delta[15:2], w[4:0]};
					end else begin
						rsp.status     = arp_pkg::ST_RANGE;
						rsp.range_form = arp_pkg::FORM_TEST;
					end
				end
				arp_pkg::CMD_ADRP: begin
					if ((&pages[51:20]) || !(|pages[51:20])) begin
						rsp.patched_value = {32'd0, w[31], pages[1:0], w[28:24],
							pages[20:2], w[4:0]};
					end else begin
						rsp.status     = arp_pkg::ST_RANGE;
						rsp.range_form = arp_pkg::FORM_PAGE;
					end
				end
				arp_pkg::CMD_ADDLO12:
					rsp.patched_value = {32'd0, w[31:22], value[11:0], w[9:0]};
				arp_pkg::CMD_LDSTLO12: begin
					if (misal) begin
						rsp.status = arp_pkg::ST_ALIGN;
					end else begin
						rsp.patched_value = {32'd0, w[31:22], lo12, w[9:0]};
					end
				end
				arp_pkg::CMD_MOVW_G0, arp_pkg::CMD_MOVW_G1,
				arp_pkg::CMD_MOVW_G2, arp_pkg::CMD_MOVW_G3:
					rsp.patched_value = {32'd0, w[31:21], half, w[4:0]};
				default: rsp.status = arp_pkg::ST_UNSUP;
			endcase
		end

		rsp.write_bytes = (rsp.status == arp_pkg::ST_OK) ? need : arp_pkg::BYTES_NONE;
	end

endmodule

FILE: rtl/aarch64_relocation_patcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_relocation_patcher
// Applies one AArch64 ELF relocation per item and returns the bytes to store.
// ----------------------------------------------------------------------------
// Each request item is captured in an input register, evaluated by one pass
// of add, range-check and field-insert logic, and the result is held in an
// output register, from which it is offered on rsp. A new item is accepted
// every cycle while results drain; when a result waits on rsp_ready the input
// register takes one more item and then req_ready drops until the output
// moves. Throughput is one item per cycle while results drain, set by the
// two-register pipeline whose ready chain reaches back through both stages.
module aarch64_relocation_patcher (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  arp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output arp_pkg::rsp_t rsp
);

	logic          valid_s1;
	arp_pkg::req_t req_s1;
	logic          valid_s2;
	arp_pkg::rsp_t rsp_s2;
	arp_pkg::rsp_t calc_rsp;
	logic          ready_s2;

	assign ready_s2  = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || ready_s2;

	arp_calc u_calc (
		.req (req_s1),
		.rsp (calc_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (valid_s1 && ready_s2) begin
			rsp_s2 <= calc_rsp;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

`ifndef ASSERT_OFF
	// a stalled item in the input register is neither lost nor overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(req_s1))
		else $error("input stage item changed while stalled");

	// an accepted item always lands in the input register
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted item not captured");

	// nothing is written on any failure status
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != arp_pkg::ST_OK |->
			rsp.write_bytes == arp_pkg::BYTES_NONE && rsp.patched_value == 64'd0)
		else $error("failed item carries write data");

	// range form only accompanies an out-of-range status
	a_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != arp_pkg::ST_RANGE |->
			rsp.range_form == arp_pkg::FORM_NONE)
		else $error("range form set without range status");
`endif

endmodule

FILE: dv/arp_relocation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_relocation_checker
// Watches both channels of the relocation patcher, predicts each patch from
// the accepted request and compares it with the returned item.
// ----------------------------------------------------------------------------
module arp_relocation_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  arp_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  arp_pkg::rsp_t rsp,
	output int            fail_count,
	output int            outstanding
);

	arp_pkg::rsp_t expected_patches[$];
	int            errors = 0;

	function automatic bit fits_signed(logic [63:0] v, int bits);
		logic [63:0] half;
		half = 64'd1 << (bits - 1);
		return (v + half) < (half << 1);
	endfunction

	function automatic logic [31:0] insert_field(logic [31:0] w, int lsb, int width,
			logic [31:0] v);
		logic [31:0] mask;
		mask = ((32'd1 << width) - 32'd1) << lsb;
		return (w & ~mask) | ((v << lsb) & mask);
	endfunction

	function automatic arp_pkg::rsp_t predict_patch(arp_pkg::req_t r);
		arp_pkg::rsp_t o;
		logic [63:0]   value, delta, q, pages, res, vpage, spage;
		logic [31:0]   w;
		logic [20:0]   imm;
		logic [3:0]    need;
		logic [2:0]    st, form;
		int            bits, lsb, sc, sh;
		value = r.target_address + r.addend;
		delta = value - r.site_address;
		w     = r.old_word;
		need  = (r.command <= arp_pkg::CMD_PREL64) ? arp_pkg::BYTES_DWORD
			: arp_pkg::BYTES_WORD;
		st    = arp_pkg::ST_OK;
		form  = arp_pkg::FORM_NONE;
		res   = '0;
		// room is tested before anything else, unsupported kinds included
		if (r.room_bytes < need) begin
			st = arp_pkg::ST_NO_ROOM;
		end else begin
			case (r.command)
				arp_pkg::CMD_ABS64:  res = value;
				arp_pkg::CMD_PREL64: res = delta;
				arp_pkg::CMD_ABS32:  res = {32'd0, value[31:0]};
				arp_pkg::CMD_PREL32: begin
					if (!fits_signed(delta, 32)) begin
						st   = arp_pkg::ST_RANGE;
						form = arp_pkg::FORM_PREL32;
					end else begin
						res = {32'd0, delta[31:0]};
					end
				end
				arp_pkg::CMD_CALL26, arp_pkg::CMD_JUMP26, arp_pkg::CMD_CONDBR19,
				arp_pkg::CMD_TSTBR14: begin
					if (r.command == arp_pkg::CMD_CONDBR19) begin
						bits = 19;
						lsb  = 5;
						form = arp_pkg::FORM_COND;
					end else if (r.command == arp_pkg::CMD_TSTBR14) begin
						bits = 14;
						lsb  = 5;
						form = arp_pkg::FORM_TEST;
					end else begin
						bits = 26;
						lsb  = 0;
						form = arp_pkg::FORM_BRANCH;
					end
					q = $signed(delta) >>> 2;
					if (delta[1:0] != 2'b00 || !fits_signed(q, bits)) begin
						st = arp_pkg::ST_RANGE;
					end else begin
						form = arp_pkg::FORM_NONE;
						res  = {32'd0, insert_field(w, lsb, bits, q[31:0])};
					end
				end
				arp_pkg::CMD_ADRP: begin
					vpage = {value[63:12], 12'd0};
					spage = {r.site_address[63:12], 12'd0};
					pages = $signed(vpage - spage) >>> 12;
					if (!fits_signed(pages, 21)) begin
						st   = arp_pkg::ST_RANGE;
						form = arp_pkg::FORM_PAGE;
					end else begin
						imm = pages[20:0];
						w   = insert_field(w, 29, 2, {30'd0, imm[1:0]});
						res = {32'd0, insert_field(w, 5, 19, {13'd0, imm[20:2]})};
					end
				end
				arp_pkg::CMD_ADDLO12:
					res = {32'd0, insert_field(w, 10, 12, {20'd0, value[11:0]})};
				arp_pkg::CMD_LDSTLO12: begin
					// 128-bit vector access scales by 16
					sc = int'(w[31:30]);
					if (w[31:30] == 2'b00 && w[26] && w[23])
						sc = 4;
					if ((value & ((64'd1 << sc) - 64'd1)) != 64'd0) begin
						st = arp_pkg::ST_ALIGN;
					end else begin
						res = {32'd0, insert_field(w, 10, 12, {20'd0, value[11:0] >> sc})};
					end
				end
				arp_pkg::CMD_MOVW_G0, arp_pkg::CMD_MOVW_G1, arp_pkg::CMD_MOVW_G2,
				arp_pkg::CMD_MOVW_G3: begin
					sh  = 16 * (int'(r.command) - int'(arp_pkg::CMD_MOVW_G0));
					q   = value >> sh;
					res = {32'd0, insert_field(w, 5, 16, {16'd0, q[15:0]})};
				end
				default: st = arp_pkg::ST_UNSUP;
			endcase
		end
		o.status        = st;
		o.write_bytes   = (st == arp_pkg::ST_OK) ? need : arp_pkg::BYTES_NONE;
		o.patched_value = (st == arp_pkg::ST_OK) ? res : 64'd0;
		o.range_form    = form;
		return o;
	endfunction

	task automatic report_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		arp_pkg::rsp_t want;
		if (!arst_n) begin
			expected_patches.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_patches.push_back(predict_patch(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_patches.size() == 0) begin
					report_failure($sformatf("unexpected item: status %0d bytes %0d value %h form %0d",
						rsp.status, rsp.write_bytes, rsp.patched_value, rsp.range_form));
				end else begin
					want = expected_patches.pop_front();
					if (want.status !== rsp.status || want.write_bytes !== rsp.write_bytes ||
							want.patched_value !== rsp.patched_value ||
							want.range_form !== rsp.range_form)
						report_failure($sformatf({"mismatch: expected status %0d bytes %0d ",
							"value %h form %0d, got status %0d bytes %0d value %h form %0d"},
							want.status, want.write_bytes, want.patched_value, want.range_form,
							rsp.status, rsp.write_bytes, rsp.patched_value, rsp.range_form));
				end
			end
			fail_count  <= errors;
			outstanding <= expected_patches.size();
		end
	end

endmodule

FILE: dv/tb_aarch64_relocation_patcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aarch64_relocation_patcher
// Drives directed corner relocations, then random ones aimed around each
// kind's range and alignment limits, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_aarch64_relocation_patcher;

	localparam logic [3:0] CMD_UNSUPPORTED = 4'd15;
	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_AFTER   = 400;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 10;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	arp_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	arp_pkg::rsp_t rsp;
	int            fail_count;
	int            outstanding;
	int            sent_count    = 0;
	bit            sender_steady = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	aarch64_relocation_patcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	arp_relocation_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// signed value of the given width, biased toward the range edges
	function automatic logic [63:0] signed_pick(int bits);
		logic signed [63:0] hi, lo, v;
		int p;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		p  = $urandom_range(0, 99);
		if (p < 65)
			v = $signed(rand64() << (64 - bits)) >>> (64 - bits);
		else if (p < 75)
			v = hi;
		else if (p < 85)
			v = lo;
		else if (p < 90)
			v = hi + 64'sd1;
		else if (p < 95)
			v = lo - 64'sd1;
		else
			v = rand64();
		return v;
	endfunction

	function automatic arp_pkg::req_t make_req(logic [3:0] cmd, logic [63:0] tgt,
			logic [63:0] add, logic [63:0] site, logic [31:0] word, logic [3:0] room);
		arp_pkg::req_t r;
		r.command        = cmd;
		r.target_address = tgt;
		r.addend         = add;
		r.site_address   = site;
		r.old_word       = word;
		r.room_bytes     = room;
		return r;
	endfunction

	// random site and addend, target chosen so that value - site = delta
	function automatic arp_pkg::req_t aim_req(logic [3:0] cmd, logic [63:0] delta,
			logic [31:0] word, logic [3:0] room);
		logic [63:0] site, add;
		site = rand64();
		add  = rand64();
		return make_req(cmd, site + delta - add, add, site, word, room);
	endfunction

	function automatic arp_pkg::req_t build_random_req();
		logic [3:0]  cmd, room;
		logic [31:0] word;
		logic [63:0] site, add, value;
		int          bits, sc;
		cmd   = 4'($urandom_range(0, 15));
		word  = $urandom;
		site  = rand64();
		add   = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
		value = rand64();
		bits  = 0;
		case (cmd)
			arp_pkg::CMD_PREL32:   value = site + signed_pick(32);
			arp_pkg::CMD_CALL26, arp_pkg::CMD_JUMP26: bits = 26;
			arp_pkg::CMD_CONDBR19: bits = 19;
			arp_pkg::CMD_TSTBR14:  bits = 14;
			arp_pkg::CMD_ADRP:
				value = {site[63:12], 12'd0} + (signed_pick(21) << 12) + $urandom_range(0, 4095);
			arp_pkg::CMD_LDSTLO12: begin
				if ($urandom_range(0, 3) == 0) begin
					word[31:30] = 2'b00;
					word[26]    = 1'b1;
					word[23]    = 1'b1;
				end
				sc = (word[31:30] == 2'b00 && word[26] && word[23]) ? 4 : int'(word[31:30]);
				if ($urandom_range(0, 4) != 0)
					value = value & ~((64'd1 << sc) - 64'd1);
			end
			default: ;
		endcase
		if (bits != 0) begin
			value = site + (signed_pick(bits) << 2);
			if ($urandom_range(0, 9) == 0)
				value = value + $urandom_range(1, 3);
		end
		if ($urandom_range(0, 9) == 0)
			room = 4'($urandom_range(0, 15));
		else
			room = 4'($urandom_range((cmd <= arp_pkg::CMD_PREL64) ? 8 : 4, 15));
		return make_req(cmd, value - add, add, site, word, room);
	endfunction

	// hold valid and payload until the item is taken
	task automatic send_request(input arp_pkg::req_t r);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic run_directed();
		send_request(make_req(arp_pkg::CMD_ABS64, '1, '1, '0, '0, 4'd8));
		send_request(make_req(arp_pkg::CMD_PREL64, '0, 64'h8000_0000_0000_0000, '1, '1, 4'd15));
		send_request(make_req(arp_pkg::CMD_ABS64, rand64(), rand64(), rand64(), $urandom, 4'd7));
		// unsupported kind: no room wins over unsupported
		send_request(make_req(CMD_UNSUPPORTED, rand64(), rand64(), rand64(), $urandom, 4'd3));
		send_request(make_req(CMD_UNSUPPORTED, rand64(), rand64(), rand64(), $urandom, 4'd15));
		send_request(make_req(arp_pkg::CMD_ABS32, '1, '0, '0, '0, 4'd4));
		send_request(aim_req(arp_pkg::CMD_PREL32, 64'h0000_0000_7FFF_FFFF, $urandom, 4'd4));
		send_request(aim_req(arp_pkg::CMD_PREL32, 64'h0000_0000_8000_0000, $urandom, 4'd8));
		send_request(aim_req(arp_pkg::CMD_CALL26, 64'h0000_0000_07FF_FFFC, '0, 4'd4));
		send_request(aim_req(arp_pkg::CMD_CALL26, 64'h0000_0000_0800_0000, '0, 4'd4));
		send_request(aim_req(arp_pkg::CMD_JUMP26, 64'hFFFF_FFFF_F800_0000, '1, 4'd4));
		send_request(aim_req(arp_pkg::CMD_JUMP26, 64'h0000_0000_0000_0002, '1, 4'd4));
		send_request(aim_req(arp_pkg::CMD_CONDBR19, 64'h0000_0000_000F_FFFC, '1, 4'd4));
		send_request(aim_req(arp_pkg::CMD_CONDBR19, 64'hFFFF_FFFF_FFEF_FFFC, '1, 4'd4));
		send_request(aim_req(arp_pkg::CMD_TSTBR14, 64'hFFFF_FFFF_FFFF_8000, '1, 4'd4));
		send_request(aim_req(arp_pkg::CMD_TSTBR14, 64'h0000_0000_0000_8000, '1, 4'd4));
		// page span at the positive limit, then one page past it
		send_request(make_req(arp_pkg::CMD_ADRP, 64'h1000_0000_FFFF_FFFF, '0,
			64'h1000_0000_0000_0000, '1, 4'd4));
		send_request(make_req(arp_pkg::CMD_ADRP, 64'h1000_0001_0000_0000, '0,
			64'h1000_0000_0000_0FFF, '0, 4'd4));
		send_request(make_req(arp_pkg::CMD_ADDLO12, '1, '0, '0, '1, 4'd4));
		send_request(make_req(arp_pkg::CMD_LDSTLO12, 64'hFF8, '0, '0, 32'hF940_0000, 4'd4));
		send_request(make_req(arp_pkg::CMD_LDSTLO12, 64'hFFC, '0, '0, 32'hF940_0000, 4'd4));
		send_request(make_req(arp_pkg::CMD_LDSTLO12, 64'hFF0, '0, '0, 32'h3DC0_0000, 4'd4));
		send_request(make_req(arp_pkg::CMD_LDSTLO12, 64'hFF8, '0, '0, 32'h3DC0_0000, 4'd4));
		for (int g = 0; g < 4; g++)
			send_request(make_req(arp_pkg::CMD_MOVW_G0 + 4'(g), 64'h1234_5678_9ABC_DEF0,
				'0, '0, '1, 4'd4));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			send_request(build_random_req());
		end
		req_valid <= 1'b0;
		// let the count take in the last accepted item before waiting on it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("aarch64_relocation_patcher regression: pass");
		else
			$display("aarch64_relocation_patcher regression: fail");
		$finish;
	end

	// result side: random stalls, one long hold-off while items keep coming
	initial begin
		int stall, run;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && sent_count >= HOLD_AFTER) begin
				stall     = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				stall = ($urandom_range(0, 7) == 0) ? 0 : pick_gap();
			end
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("aarch64_relocation_patcher regression: fail");
		$finish;
	end

endmodule
